FILE: hdl/assert_macros.svh
// Assertion macros shared by the selector RTL.
// Needs a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/csvs_pkg.sv
// Types and register codes for the closest-size variant selector.
// No dependencies; the RTL files refer to it by scoped names.
package csvs_pkg;

	typedef struct packed {
		logic        is_candidate;
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0]  quality;
		logic        last;
	} item_t;

	typedef struct packed {
		logic       found;
		logic [7:0] chosen_index;
	} result_t;

	typedef struct packed {
		logic [15:0] desired_width;
		logic [15:0] desired_height;
		logic        rights_valid;
	} cfg_t;

	// Dimensions and quality of the variant chosen so far.
	typedef struct packed {
		logic [7:0]  quality;
		logic [15:0] width;
		logic [15:0] height;
	} best_t;

	localparam int unsigned ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_DESIRED_WIDTH  = 2'd0,
		REG_DESIRED_HEIGHT = 2'd1,
		REG_RIGHTS_VALID   = 2'd2,
		REG_UNUSED         = 2'd3
	} reg_idx_t;

endpackage

FILE: hdl/csvs_decide.sv
// Replacement decision for one candidate against the current choice.
// Depends on csvs_pkg for the item, configuration and choice types.
module csvs_decide (
	input  csvs_pkg::item_t item,
	input  csvs_pkg::cfg_t  cfg,
	input  csvs_pkg::best_t best,
	output logic            take
);

	logic [31:0] prod_h;
	logic [31:0] prod_w;
	logic        use_height;
	logic [15:0] cur;
	logic [15:0] sel;
	logic [15:0] req;
	logic        prefer;

	// Cross-multiplied aspect test: compare heights when the item is at
	// least as tall, relative to its width, as the request.
	assign prod_h     = 32'(item.height) * 32'(cfg.desired_width);
	assign prod_w     = 32'(cfg.desired_height) * 32'(item.width);
	assign use_height = (prod_h >= prod_w);

	always_comb begin
		cur = use_height ? item.height : item.width;
		sel = use_height ? best.height : best.width;
		req = use_height ? cfg.desired_height : cfg.desired_width;
		if (cur == sel) begin
			prefer = (item.quality > best.quality);
		end else if (cur < req) begin
			prefer = (sel < cur);
		end else if (cur > req) begin
			prefer = cfg.rights_valid && ((sel < req) || (cur < sel));
		end else begin
			prefer = 1'b1;
		end
		take = item.is_candidate && prefer;
	end

endmodule

FILE: hdl/closest_size_variant_selector_unit.sv
// Closest-size variant selector: streams a list of variants and reports the best fit.
// Depends on csvs_pkg, csvs_decide and assert_macros.svh.
//
// Usage: program desired_width (0x0), desired_height (0x4) and rights_valid (0x8)
// over the APB port while the block is idle. Then send the variant list on the
// item channel, one transaction per entry, with last set on the final entry.
// Non-last entries produce nothing; the last entry produces one transaction on
// the result channel with found and chosen_index (0 when nothing was chosen).
// Entry positions are counted internally from 0 and wrap at MAX_ENTRIES.
// An item is registered on acceptance and evaluated from that input register;
// result_valid comes from a register that loads when the last item is evaluated.
// Throughput: one item per cycle while no last item is held back, set by the
// compare-and-update loop on the running choice (two 16x16 multiplies and a few compares).
// When the result receiver stalls, non-last items keep flowing; only a second
// last item waits in the input register until the pending result is taken.
// Reset clears the registers, the position counter and the running choice;
// after each list the running choice and position clear again, registers stay.
module closest_size_variant_selector_unit #(
	parameter int unsigned MAX_ENTRIES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  csvs_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output csvs_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [csvs_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	`include "assert_macros.svh"

	localparam int unsigned PW = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned IW = (PW > 8) ? PW : 8;
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_ENTRIES - 1);

	csvs_pkg::cfg_t    cfg_q;
	csvs_pkg::item_t   item_s1;
	logic              valid_s1;
	logic [PW-1:0]     pos_q;
	logic              have_q;
	logic [PW-1:0]     best_idx_q;
	csvs_pkg::best_t   best_q;
	logic              res_valid_q;
	csvs_pkg::result_t res_q;

	logic              take;
	logic              go_s1;
	logic              res_load;
	logic              item_fire;
	logic              cfg_wr;
	csvs_pkg::reg_idx_t reg_idx;
	logic [PW-1:0]     res_idx;
	logic [IW-1:0]     res_idx_ext;

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = csvs_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		case (reg_idx)
			csvs_pkg::REG_DESIRED_WIDTH:  prdata = {16'd0, cfg_q.desired_width};
			csvs_pkg::REG_DESIRED_HEIGHT: prdata = {16'd0, cfg_q.desired_height};
			csvs_pkg::REG_RIGHTS_VALID:   prdata = {31'd0, cfg_q.rights_valid};
			default:                      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				csvs_pkg::REG_DESIRED_WIDTH:  cfg_q.desired_width  <= pwdata[15:0];
				csvs_pkg::REG_DESIRED_HEIGHT: cfg_q.desired_height <= pwdata[15:0];
				csvs_pkg::REG_RIGHTS_VALID:   cfg_q.rights_valid   <= pwdata[0];
				default: ;
			endcase
		end
	end

	csvs_decide u_decide (
		.item (item_s1),
		.cfg  (cfg_q),
		.best (best_q),
		.take (take)
	);

	// A last item in the input register waits only while a result is still pending.
	assign go_s1      = valid_s1 && !(item_s1.last && res_valid_q && !result_ready);
	assign item_ready = !valid_s1 || go_s1;
	assign item_fire  = item_valid && item_ready;
	assign res_load   = go_s1 && item_s1.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			item_s1 <= item;
		end
	end

	// Running choice and position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			have_q     <= 1'b0;
			best_idx_q <= '0;
			best_q     <= '0;
		end else if (go_s1) begin
			if (item_s1.last) begin
				pos_q      <= '0;
				have_q     <= 1'b0;
				best_idx_q <= '0;
				best_q     <= '0;
			end else begin
				pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
				if (take) begin
					have_q         <= 1'b1;
					best_idx_q     <= pos_q;
					best_q.quality <= item_s1.quality;
					best_q.width   <= item_s1.width;
					best_q.height  <= item_s1.height;
				end
			end
		end
	end

	assign res_idx     = take ? pos_q : best_idx_q;
	assign res_idx_ext = IW'(res_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.found        <= have_q || take;
			res_q.chosen_index <= (have_q || take) ? res_idx_ext[7:0] : 8'd0;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	`ASSERT_IMPL(a_no_overwrite, res_valid_q && !result_ready, !res_load,
		"pending result would be overwritten")
	`ASSERT_NEXT(a_clear_after_last, res_load, (pos_q == '0) && !have_q,
		"running choice not cleared after last item")
	`ASSERT_IMPL(a_index_zero_when_absent, res_valid_q && !res_q.found,
		res_q.chosen_index == 8'd0, "chosen_index nonzero without a choice")
	`ASSERT_IMPL(a_pos_in_range, 1'b1, pos_q <= POS_LAST,
		"position counter beyond MAX_ENTRIES")

endmodule
